### rtl/core/tstm_pkg.sv
// Package for the touch-sample trimmed-mean unit.
// Holds field widths, the group length and the control struct shared by
// the axis accumulator and the top level. No dependencies.
`default_nettype none

package tstm_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned NibbleW    = 4;
  localparam int unsigned SampleW    = 12;
  localparam int unsigned TotalW     = 16;
  localparam int unsigned CountW     = 4;
  localparam int unsigned TrimShift  = 3;
  localparam int unsigned GroupSize  = 10;
  localparam int unsigned InDataW    = 4 * ByteW;
  localparam int unsigned OutDataW   = 2 * SampleW;

  localparam logic [SampleW-1:0] SampleMax  = {SampleW{1'b1}};
  localparam logic [CountW-1:0]  LastCount  = CountW'(GroupSize - 1);

  // Control from the sequencing logic to each axis accumulator
  typedef struct packed {
    logic update;      // take the staged sample this cycle
    logic group_last;  // the staged sample closes the group
  } acc_ctrl_t;

endpackage : tstm_pkg

`default_nettype wire

### rtl/core/tstm_axis_acc.sv
// Per-axis running minimum, maximum and sum over one group of samples.
// Produces the trimmed mean of the group including the sample being taken.
// Depends on tstm_pkg.
`default_nettype none

module tstm_axis_acc (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tstm_pkg::acc_ctrl_t           ctrl_i,
  input  wire logic [tstm_pkg::SampleW-1:0]  sample_i,
  output logic      [tstm_pkg::SampleW-1:0]  position_o
);

  logic [tstm_pkg::SampleW-1:0] least_q, least_d, least_n;
  logic [tstm_pkg::SampleW-1:0] greatest_q, greatest_d, greatest_n;
  logic [tstm_pkg::TotalW-1:0]  total_q, total_d, total_n;
  logic [tstm_pkg::TotalW-1:0]  trim_sum;

  // Fold the sample into the running extremes and sum
  always_comb begin
    least_n    = (sample_i < least_q) ? sample_i : least_q;
    greatest_n = (sample_i > greatest_q) ? sample_i : greatest_q;
    total_n    = total_q + tstm_pkg::TotalW'(sample_i);
    trim_sum   = total_n - tstm_pkg::TotalW'(least_n) - tstm_pkg::TotalW'(greatest_n);
    position_o = trim_sum[tstm_pkg::TrimShift +: tstm_pkg::SampleW];
  end

  // Advance on each taken sample, clear after the last one of a group
  always_comb begin
    least_d    = least_q;
    greatest_d = greatest_q;
    total_d    = total_q;
    if (ctrl_i.update) begin
      if (ctrl_i.group_last) begin
        least_d    = tstm_pkg::SampleMax;
        greatest_d = '0;
        total_d    = '0;
      end else begin
        least_d    = least_n;
        greatest_d = greatest_n;
        total_d    = total_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      least_q    <= tstm_pkg::SampleMax;
      greatest_q <= '0;
      total_q    <= '0;
    end else begin
      least_q    <= least_d;
      greatest_q <= greatest_d;
      total_q    <= total_d;
    end
  end

endmodule : tstm_axis_acc

`default_nettype wire

### rtl/core/touch_sample_trimmed_mean_unit.sv
// Top level of the touch-sample trimmed-mean unit: input stage, group
// counter, two axis accumulators and the result register.
// Depends on tstm_pkg and tstm_axis_acc.
//
//  channel | dir | tdata fields (low bit up)                         | extra
//  s_axis  | in  | x_high_byte 8, x_low_byte 8, y_high_byte 8,        | -
//          |     | y_low_byte 8                                      |
//  m_axis  | out | x_position 12, y_position 12                      | -
//
// One reading is taken per cycle while the input stage is not stalled; it is
// staged in an input register and folded into the accumulators as the stage
// drains. Every tenth reading loads the result register as it leaves the stage.
// A pending result stalls the input stage only when the staged reading closes
// the next group. Reset clears the counter, the accumulators and all valids.
`default_nettype none

module touch_sample_trimmed_mean_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // x_high_byte [7:0], x_low_byte [15:8], y_high_byte [23:16], y_low_byte [31:24]
  input  wire logic [tstm_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // x_position [11:0], y_position [23:12]
  output logic      [tstm_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  localparam int unsigned B = tstm_pkg::ByteW;

  logic                          in_accept;
  logic [tstm_pkg::SampleW-1:0]  x_sample, y_sample;
  logic                          stage_valid_q, stage_valid_d;
  logic [tstm_pkg::SampleW-1:0]  x_stage_q, y_stage_q;
  logic [tstm_pkg::CountW-1:0]   count_q, count_d;
  logic                          stage_last;
  logic                          stage_fire;
  tstm_pkg::acc_ctrl_t           acc_ctrl;
  logic [tstm_pkg::SampleW-1:0]  x_position, y_position;
  logic                          out_valid_q, out_valid_d;
  logic [tstm_pkg::OutDataW-1:0] out_data_q;

  // Assemble samples: high byte over the upper nibble of the low byte
  assign x_sample = {s_axis_tdata_i[0 +: B],
                     s_axis_tdata_i[B + tstm_pkg::NibbleW +: tstm_pkg::NibbleW]};
  assign y_sample = {s_axis_tdata_i[2*B +: B],
                     s_axis_tdata_i[3*B + tstm_pkg::NibbleW +: tstm_pkg::NibbleW]};

  // Drain the stage unless it closes a group and the result slot stays full
  assign stage_last = (count_q == tstm_pkg::LastCount);
  assign stage_fire = stage_valid_q &&
                      (!stage_last || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !stage_valid_q || stage_fire;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  assign acc_ctrl.update     = stage_fire;
  assign acc_ctrl.group_last = stage_last;

  // Advance the group counter and stage valid
  always_comb begin
    count_d = count_q;
    if (stage_fire) begin
      count_d = stage_last ? '0 : count_q + 1'b1;
    end
    if (in_accept) begin
      stage_valid_d = 1'b1;
    end else if (stage_fire) begin
      stage_valid_d = 1'b0;
    end else begin
      stage_valid_d = stage_valid_q;
    end
  end

  // Hold a result until its transfer completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (stage_fire && stage_last) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      count_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
      count_q       <= count_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_stage_q <= x_sample;
      y_stage_q <= y_sample;
    end
    if (stage_fire && stage_last) begin
      out_data_q <= {y_position, x_position};
    end
  end

  tstm_axis_acc u_x_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (acc_ctrl),
    .sample_i   (x_stage_q),
    .position_o (x_position)
  );

  tstm_axis_acc u_y_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (acc_ctrl),
    .sample_i   (y_stage_q),
    .position_o (y_position)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule : touch_sample_trimmed_mean_unit

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for touch_sample_trimmed_mean_unit: streams raw
// touch readings, predicts every group's trimmed-mean position and checks it.
// Depends on tstm_pkg and the RTL of the unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Result layout on m_axis_tdata: x_position low, y_position high
  typedef struct packed {
    logic [tstm_pkg::SampleW-1:0] y;
    logic [tstm_pkg::SampleW-1:0] x;
  } position_t;

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  // x_high_byte [7:0], x_low_byte [15:8], y_high_byte [23:16], y_low_byte [31:24]
  logic [tstm_pkg::InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  // x_position [11:0], y_position [23:12]
  logic [tstm_pkg::OutDataW-1:0] m_axis_tdata_o;

  touch_sample_trimmed_mean_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Readings waiting to be sent, group results waiting to come out
  logic [tstm_pkg::InDataW-1:0] readings_q[$];
  position_t                    positions_q[$];
  int                           readings_issued = 0;
  int                           readings_taken  = 0;
  int                           mismatch_count  = 0;

  // Predicted accumulator state of the unit
  logic [tstm_pkg::CountW-1:0]  grp_count;
  logic [tstm_pkg::SampleW-1:0] x_min, x_max, y_min, y_max;
  logic [tstm_pkg::TotalW-1:0]  x_sum, y_sum;

  bit src_steady = 1'b0;
  bit snk_steady = 1'b0;
  int src_gap;
  int snk_gap;
  position_t got_pos, want_pos;

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap(input bit steady);
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic clear_group();
    grp_count = '0;
    x_min = tstm_pkg::SampleMax;
    x_max = '0;
    x_sum = '0;
    y_min = tstm_pkg::SampleMax;
    y_max = '0;
    y_sum = '0;
  endtask

  // Fold one accepted reading into the group; queue a position on the tenth
  task automatic fold_reading(input logic [tstm_pkg::InDataW-1:0] reading);
    logic [tstm_pkg::SampleW-1:0] xs, ys;
    logic [tstm_pkg::TotalW-1:0]  x_trim, y_trim;
    position_t                    pos;
    xs = {reading[7:0], reading[15:12]};
    ys = {reading[23:16], reading[31:28]};
    if (xs < x_min) x_min = xs;
    if (xs > x_max) x_max = xs;
    if (ys < y_min) y_min = ys;
    if (ys > y_max) y_max = ys;
    x_sum = x_sum + tstm_pkg::TotalW'(xs);
    y_sum = y_sum + tstm_pkg::TotalW'(ys);
    grp_count = grp_count + 1'b1;
    if (grp_count >= tstm_pkg::CountW'(tstm_pkg::GroupSize)) begin
      x_trim = x_sum - tstm_pkg::TotalW'(x_min) - tstm_pkg::TotalW'(x_max);
      y_trim = y_sum - tstm_pkg::TotalW'(y_min) - tstm_pkg::TotalW'(y_max);
      pos.x = tstm_pkg::SampleW'(x_trim >> tstm_pkg::TrimShift);
      pos.y = tstm_pkg::SampleW'(y_trim >> tstm_pkg::TrimShift);
      positions_q.push_back(pos);
      clear_group();
    end
  endtask

  task automatic push_reading(input logic [7:0] x_hi, input logic [7:0] x_lo,
                              input logic [7:0] y_hi, input logic [7:0] y_lo);
    readings_q.push_back({y_lo, y_hi, x_lo, x_hi});
    readings_issued++;
  endtask

  // Split 12-bit samples into bytes, random junk in the dropped low nibbles
  task automatic push_sample(input logic [tstm_pkg::SampleW-1:0] xs,
                             input logic [tstm_pkg::SampleW-1:0] ys);
    push_reading(xs[11:4], {xs[3:0], 4'($urandom)}, ys[11:4], {ys[3:0], 4'($urandom)});
  endtask

  // Jitter around a resting point, clamped to the sample range
  function automatic logic [tstm_pkg::SampleW-1:0] near(
    input logic [tstm_pkg::SampleW-1:0] base);
    int v;
    v = int'(base) + $urandom_range(0, 80) - 40;
    if (v < 0) v = 0;
    if (v > int'(tstm_pkg::SampleMax)) v = int'(tstm_pkg::SampleMax);
    return tstm_pkg::SampleW'(v);
  endfunction

  // One group of readings: raw noise, a held touch, rail values or a constant
  task automatic queue_group();
    int                           mode;
    int                           k;
    logic [tstm_pkg::SampleW-1:0] x_base, y_base;
    mode   = $urandom_range(0, 9);
    x_base = tstm_pkg::SampleW'($urandom_range(0, tstm_pkg::SampleMax));
    y_base = tstm_pkg::SampleW'($urandom_range(0, tstm_pkg::SampleMax));
    for (k = 0; k < tstm_pkg::GroupSize; k++) begin
      case (mode)
        0, 1, 2: begin
          push_reading(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
        3, 4, 5, 6: begin
          push_sample(near(x_base), near(y_base));
        end
        7: begin
          push_sample($urandom_range(0, 1) ? tstm_pkg::SampleMax : '0,
                      $urandom_range(0, 1) ? tstm_pkg::SampleMax : '0);
        end
        default: begin
          push_sample(x_base, y_base);
        end
      endcase
    end
  endtask

  // Hold until every reading is taken and every position has come out
  task automatic wait_drained();
    while (readings_taken != readings_issued) @(posedge clk_i);
    while (positions_q.size() != 0) @(posedge clk_i);
  endtask

  // Driver: present the next reading once the current transfer completes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      src_gap         <= 0;
      clear_group();
    end else begin
      if ($urandom_range(0, 199) == 0) src_steady <= !src_steady;
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (s_axis_tvalid_i) begin
          fold_reading(s_axis_tdata_i);
          readings_taken++;
        end
        if (src_gap != 0 || readings_q.size() == 0) begin
          if (src_gap != 0) src_gap <= src_gap - 1;
          s_axis_tvalid_i <= 1'b0;
        end else begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= readings_q.pop_front();
          src_gap         <= pick_gap(src_steady);
        end
      end
    end
  end

  // Monitor: check each position transfer, then stall the receive side at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      snk_gap         <= 0;
    end else begin
      if ($urandom_range(0, 199) == 0) snk_steady <= !snk_steady;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_pos = m_axis_tdata_o;
        if (positions_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: unexpected position x=%0d y=%0d", got_pos.x, got_pos.y);
        end else begin
          want_pos = positions_q.pop_front();
          if (got_pos.x !== want_pos.x || got_pos.y !== want_pos.y) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("ERROR: position mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                       want_pos.x, want_pos.y, got_pos.x, got_pos.y);
          end
        end
      end
      if (snk_gap != 0) begin
        snk_gap         <= snk_gap - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        snk_gap         <= pick_gap(snk_steady);
      end
    end
  end

  // Stimulus and end of test
  initial begin
    int g;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full-scale group: every sample at the top, ties at both extremes
    for (g = 0; g < tstm_pkg::GroupSize; g++) push_reading(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // Mixed group: zeros, rails, dropped low nibbles, repeated min and max
    push_reading(8'h00, 8'h00, 8'h00, 8'h00);
    push_reading(8'hFF, 8'h0F, 8'h00, 8'hF0);
    push_reading(8'h00, 8'hFF, 8'hFF, 8'h00);
    push_reading(8'h80, 8'h7F, 8'h7F, 8'h80);
    push_reading(8'h00, 8'h00, 8'h00, 8'h00);
    push_reading(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_reading(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_reading(8'h12, 8'h34, 8'h56, 8'h78);
    push_reading(8'hA5, 8'h5A, 8'h5A, 8'hA5);
    push_reading(8'h01, 8'h1F, 8'h10, 8'h01);
    // Let the unit go fully idle before the random traffic
    wait_drained();

    for (g = 0; g < 80; g++) queue_group();
    wait_drained();
    for (g = 0; g < 85; g++) queue_group();
    wait_drained();
    repeat (20) @(posedge clk_i);

    if (positions_q.size() != 0) begin
      $display("ERROR: %0d positions never came out", positions_q.size());
      mismatch_count += positions_q.size();
    end
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("ERROR: timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
rtl/core/tstm_pkg.sv
rtl/core/tstm_axis_acc.sv
rtl/core/touch_sample_trimmed_mean_unit.sv
dv/tb_top.sv
